### sv/gauge_needle_renderer_core_assert.svh
// Assertion macros shared by the gauge needle renderer RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef GAUGE_NEEDLE_RENDERER_CORE_ASSERT_SVH
`define GAUGE_NEEDLE_RENDERER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GNR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GNR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/gnr_pkg.sv
// Shared types, constants and lookup functions for the gauge needle renderer.
// Used by gnr_div, gnr_line and gauge_needle_renderer_core; depends on nothing else.
`default_nettype none

package gnr_pkg;

    localparam int CELLS     = 8;
    localparam int CELL_ROWS = 8;
    localparam int CELL_W    = 5;
    localparam int BITMAP_W  = CELL_ROWS * CELL_W;

    localparam logic [7:0]  FS_RESET  = 8'd90;
    // Angle span 300 - 112 degrees; the 1/256 degree scaling is a shift of the product.
    localparam logic [15:0] SCALE_MUL = 16'd188;
    localparam logic [16:0] ANGLE_MIN = 17'd28672;

    localparam int DIV_STEPS = 24;
    localparam int QUOT_W    = 16;

    localparam logic signed [5:0] HUB_X = 6'sd10;
    localparam logic signed [5:0] HUB_Y = 6'sd8;

    // Word index of the configuration registers.
    localparam logic REG_FULL_SCALE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOOK,
        ST_SETUP,
        ST_DRAW,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [4:0] x;
        logic [3:0] y;
    } t_pix;

    typedef struct packed {
        logic [2:0] cell_idx;
        logic [5:0] pos;
    } t_place;

    localparam logic [4:0] DIAL_ROM [CELLS][CELL_ROWS] = '{
        '{5'h00, 5'h00, 5'h00, 5'h01, 5'h03, 5'h02, 5'h02, 5'h02},
        '{5'h07, 5'h08, 5'h18, 5'h04, 5'h00, 5'h10, 5'h00, 5'h00},
        '{5'h1E, 5'h11, 5'h11, 5'h02, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h10, 5'h08, 5'h0C, 5'h14, 5'h04, 5'h04},
        '{5'h03, 5'h02, 5'h02, 5'h02, 5'h01, 5'h00, 5'h00, 5'h00},
        '{5'h10, 5'h00, 5'h00, 5'h08, 5'h10, 5'h12, 5'h0C, 5'h07},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h01, 5'h1E},
        '{5'h1C, 5'h04, 5'h04, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00}
    };

    // Each entry holds the first angle (1/256 degree) from which its offset applies.
    localparam logic [16:0] COS_FROM [16] = '{
        17'd0,     17'd30720, 17'd33282, 17'd36298, 17'd40503, 17'd51658,
        17'd55863, 17'd58879, 17'd61441, 17'd63764, 17'd65953, 17'd68072,
        17'd70169, 17'd72288, 17'd74477, 17'd76800
    };
    localparam logic signed [3:0] COS_VAL [16] = '{
        -4'sd3, -4'sd4, -4'sd5, -4'sd6, -4'sd7, -4'sd6, -4'sd5, -4'sd4,
        -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4
    };
    localparam logic [16:0] SIN_FROM [15] = '{
        17'd0,     17'd32823, 17'd35839, 17'd38401, 17'd40724, 17'd42913,
        17'd45032, 17'd47129, 17'd49248, 17'd51437, 17'd53760, 17'd56322,
        17'd59338, 17'd63543, 17'd74698
    };
    localparam logic signed [3:0] SIN_VAL [15] = '{
        4'sd6, 4'sd5, 4'sd4, 4'sd3, 4'sd2, 4'sd1, 4'sd0, -4'sd1,
        -4'sd2, -4'sd3, -4'sd4, -4'sd5, -4'sd6, -4'sd7, -4'sd6
    };

    function automatic logic signed [3:0] cos_lut(input logic [16:0] angle);
        logic signed [3:0] v;
        v = COS_VAL[0];
        for (int i = 1; i < 16; i++) begin
            if (angle >= COS_FROM[i]) begin
                v = COS_VAL[i];
            end
        end
        return v;
    endfunction

    function automatic logic signed [3:0] sin_lut(input logic [16:0] angle);
        logic signed [3:0] v;
        v = SIN_VAL[0];
        for (int i = 1; i < 15; i++) begin
            if (angle >= SIN_FROM[i]) begin
                v = SIN_VAL[i];
            end
        end
        return v;
    endfunction

    // Background bitmap of one cell, row r in bits 5r+4..5r.
    function automatic logic [BITMAP_W-1:0] dial_cell(input logic [2:0] cell_idx);
        logic [BITMAP_W-1:0] bits;
        bits = '0;
        for (int r = 0; r < CELL_ROWS; r++) begin
            bits[r*CELL_W +: CELL_W] = DIAL_ROM[cell_idx][r];
        end
        return bits;
    endfunction

    // Maps a canvas pixel to its cell and its bit inside the cell bitmap.
    function automatic t_place pix_place(input logic [4:0] x, input logic [3:0] y);
        t_place     pl;
        logic [1:0] col;
        logic [4:0] xm;
        if (x < 5'd5) begin
            col = 2'd0;
            xm  = x;
        end else if (x < 5'd10) begin
            col = 2'd1;
            xm  = x - 5'd5;
        end else if (x < 5'd15) begin
            col = 2'd2;
            xm  = x - 5'd10;
        end else begin
            col = 2'd3;
            xm  = x - 5'd15;
        end
        pl.cell_idx = {y[3], col};
        pl.pos      = 6'(6'(y[2:0]) * 6'd5) + (6'd4 - 6'(xm));
        return pl;
    endfunction

endpackage

`default_nettype wire

### sv/gnr_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Takes its widths from gnr_pkg; used by gauge_needle_renderer_core for the angle scaling.
`default_nettype none

module gnr_div
    import gnr_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire  [DIV_STEPS-1:0]    i_num,
    input  wire  [7:0]              i_den,
    output logic                    o_done,
    output logic [QUOT_W-1:0]       o_quot
);

    logic                   r_busy;
    logic                   r_done;
    logic [4:0]             r_cnt;
    logic [7:0]             r_rem;
    logic [7:0]             r_den;
    logic [DIV_STEPS-1:0]   r_q;

    logic [8:0]             n_shift;
    logic                   n_ge;
    logic [7:0]             n_rem;

    // The remainder stays below the divisor, so the shifted value fits nine bits.
    always_comb begin
        n_shift = {r_rem, r_q[DIV_STEPS-1]};
        n_ge    = n_shift >= {1'b0, r_den};
        n_rem   = n_ge ? 8'(n_shift - {1'b0, r_den}) : n_shift[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 5'd1;
            r_done <= r_cnt == 5'(DIV_STEPS - 1);
            r_busy <= r_cnt != 5'(DIV_STEPS - 1);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[DIV_STEPS-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[QUOT_W-1:0];

endmodule

`default_nettype wire

### sv/gnr_line.sv
// Bresenham line walker between the dial hub and the needle tip, one pixel per cycle.
// Uses t_pix and the hub constants from gnr_pkg; driven by gauge_needle_renderer_core.
`default_nettype none

module gnr_line
    import gnr_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire signed [3:0]    i_dx,
    input  wire signed [3:0]    i_dy,
    output t_pix                o_pix
);

    logic               r_busy;
    logic [2:0]         r_cnt;
    logic               r_steep;
    logic               r_neg;
    logic [2:0]         r_amaj;
    logic [2:0]         r_amin;
    logic [4:0]         r_x;
    logic [3:0]         r_y;
    logic signed [5:0]  r_d;

    logic [2:0]         n_adx;
    logic [2:0]         n_ady;
    logic               n_steep;
    logic               n_swap;
    logic               n_neg;
    logic [2:0]         n_amaj;
    logic [2:0]         n_amin;
    logic signed [5:0]  n_sx;
    logic signed [5:0]  n_sy;
    logic signed [5:0]  n_d0;
    logic               n_up;
    logic signed [5:0]  n_d;

    // Setup: the walk always runs forward along the major axis, so a line that
    // points backward starts from the needle tip instead of the hub.
    always_comb begin
        n_adx   = i_dx < 0 ? 3'(-i_dx) : 3'(i_dx);
        n_ady   = i_dy < 0 ? 3'(-i_dy) : 3'(i_dy);
        n_steep = !(n_ady < n_adx);
        n_swap  = n_steep ? (i_dy < 0) : (i_dx < 0);
        if (n_steep) begin
            n_neg  = n_swap ? (i_dx > 0) : (i_dx < 0);
            n_amaj = n_ady;
            n_amin = n_adx;
        end else begin
            n_neg  = n_swap ? (i_dy > 0) : (i_dy < 0);
            n_amaj = n_adx;
            n_amin = n_ady;
        end
        n_sx = n_swap ? HUB_X + 6'(i_dx) : HUB_X;
        n_sy = n_swap ? HUB_Y + 6'(i_dy) : HUB_Y;
        n_d0 = $signed({2'b00, n_amin, 1'b0}) - $signed({3'b000, n_amaj});
    end

    always_comb begin
        n_up = r_d > 0;
        n_d  = r_d + $signed({2'b00, r_amin, 1'b0})
             - (n_up ? $signed({2'b00, r_amaj, 1'b0}) : 6'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == 3'd0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt   <= n_amaj;
            r_steep <= n_steep;
            r_neg   <= n_neg;
            r_amaj  <= n_amaj;
            r_amin  <= n_amin;
            r_x     <= n_sx[4:0];
            r_y     <= n_sy[3:0];
            r_d     <= n_d0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 3'd1;
            r_d   <= n_d;
            if (r_steep) begin
                r_y <= r_y + 4'd1;
                if (n_up) begin
                    r_x <= r_neg ? r_x - 5'd1 : r_x + 5'd1;
                end
            end else begin
                r_x <= r_x + 5'd1;
                if (n_up) begin
                    r_y <= r_neg ? r_y - 4'd1 : r_y + 4'd1;
                end
            end
        end
    end

    always_comb begin
        o_pix.valid = r_busy;
        o_pix.last  = r_busy && r_cnt == 3'd0;
        o_pix.x     = r_x;
        o_pix.y     = r_y;
    end

endmodule

`default_nettype wire

### sv/gauge_needle_renderer_core.sv
// Gauge needle renderer: reading to needle angle, line walk, and cell output.
// Depends on gnr_pkg, gnr_div, gnr_line and gauge_needle_renderer_core_assert.svh.
//
// Usage: the input channel (i_psi_valid, o_psi_stall, i_psi) takes one pressure item
// at a time. Each item gives eight result items on the output channel (o_cell_valid,
// i_cell_stall), cells 0 through 7 in order, with o_last_cell set on cell 7.
// The angle is scaled by a 24-step restoring divider, one quotient bit a cycle,
// followed by a lookup state, a setup state and a line walk. o_psi_stall stays high
// from acceptance until cell 7 is loaded into the output register, so the next item
// can be taken while cell 7 still waits. A stall on the output simply holds the
// current cell and pauses the cell sequence. full_scale_psi is written through the
// APB port at byte address 0 and reads back there. Synchronous reset sets
// full_scale_psi to 90, returns to idle and drops o_cell_valid; no clearing pass is
// needed.
`default_nettype none
`include "gauge_needle_renderer_core_assert.svh"

module gauge_needle_renderer_core
    import gnr_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,

    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [2:0]              paddr,
    input  wire  [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,

    input  wire                     i_psi_valid,
    output logic                    o_psi_stall,
    input  wire  [7:0]              i_psi,

    output logic                    o_cell_valid,
    input  wire                     i_cell_stall,
    output logic [2:0]              o_cell_index,
    output logic [BITMAP_W-1:0]     o_cell_bitmap,
    output logic                    o_last_cell
);

    t_state                 r_state;
    t_state                 n_state;

    logic [7:0]             r_fs;
    logic                   r_fzero;
    logic signed [3:0]      r_dx;
    logic signed [3:0]      r_dy;
    logic [2:0]             r_npix;
    logic [CELLS-1:0]       r_slot_v;
    logic [2:0]             r_slot_cell [CELLS];
    logic [5:0]             r_slot_pos  [CELLS];
    logic [2:0]             r_cell;
    logic                   r_ov;
    logic [2:0]             r_oidx;
    logic [BITMAP_W-1:0]    r_obits;
    logic                   r_olast;

    logic                   in_ready;
    logic                   in_accept;
    logic                   line_start;
    logic                   look_en;
    logic                   pix_store;
    logic                   emit_load;
    logic                   cfg_write;

    logic [7:0]             p_clamp;
    logic [15:0]            prod;
    logic [DIV_STEPS-1:0]   num;
    logic                   div_done;
    logic [QUOT_W-1:0]      quot;
    logic [16:0]            angle;
    t_pix                   pix;
    t_place                 place;
    logic [BITMAP_W-1:0]    cell_bits;

    gnr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_num   (num),
        .i_den   (r_fs),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    gnr_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (line_start),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_pix   (pix)
    );

    // Configuration port
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_FULL_SCALE) ? {24'd0, r_fs} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= FS_RESET;
        end else if (cfg_write && paddr[2] == REG_FULL_SCALE) begin
            r_fs <= pwdata[7:0];
        end
    end

    // Numerator 188*256*p with the reading clamped to full scale.
    always_comb begin
        p_clamp = (i_psi > r_fs) ? r_fs : i_psi;
        prod    = 16'(16'(p_clamp) * SCALE_MUL);
        num     = {prod, 8'h00};
        angle   = ANGLE_MIN + 17'(r_fzero ? '0 : quot);
        place   = pix_place(pix.x, pix.y);
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_accept) begin
                n_state = ST_DIV;
            end
            ST_DIV:   if (div_done) begin
                n_state = ST_LOOK;
            end
            ST_LOOK:  n_state = ST_SETUP;
            ST_SETUP: n_state = ST_DRAW;
            ST_DRAW:  if (pix.valid && pix.last) begin
                n_state = ST_EMIT;
            end
            ST_EMIT:  if (emit_load && r_cell == 3'(CELLS - 1)) begin
                n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = r_state == ST_IDLE;
        in_accept  = in_ready && i_psi_valid;
        look_en    = r_state == ST_LOOK;
        line_start = r_state == ST_SETUP;
        pix_store  = r_state == ST_DRAW && pix.valid;
        emit_load  = r_state == ST_EMIT && (!r_ov || !i_cell_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fzero <= r_fs == 8'd0;
        end
        if (look_en) begin
            r_dx <= cos_lut(angle);
            r_dy <= sin_lut(angle);
        end
    end

    // Needle pixel slots; a frame holds at most eight pixels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_v <= '0;
            r_npix   <= '0;
            r_cell   <= '0;
        end else if (in_accept) begin
            r_slot_v <= '0;
            r_npix   <= '0;
            r_cell   <= '0;
        end else begin
            if (pix_store) begin
                r_slot_v[r_npix] <= 1'b1;
                r_npix           <= r_npix + 3'd1;
            end
            if (emit_load) begin
                r_cell <= r_cell + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_store) begin
            r_slot_cell[r_npix] <= place.cell_idx;
            r_slot_pos[r_npix]  <= place.pos;
        end
    end

    always_comb begin
        cell_bits = dial_cell(r_cell);
        for (int i = 0; i < CELLS; i++) begin
            if (r_slot_v[i] && r_slot_cell[i] == r_cell) begin
                cell_bits = cell_bits | (BITMAP_W'(1) << r_slot_pos[i]);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit_load) begin
            r_ov <= 1'b1;
        end else if (!i_cell_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_oidx  <= r_cell;
            r_obits <= cell_bits;
            r_olast <= r_cell == 3'(CELLS - 1);
        end
    end

    assign o_psi_stall   = !in_ready;
    assign o_cell_valid  = r_ov;
    assign o_cell_index  = r_oidx;
    assign o_cell_bitmap = r_obits;
    assign o_last_cell   = r_olast;

    `GNR_ASSERT_NXT(a_cell_order, o_cell_valid && !i_cell_stall && !o_last_cell, !o_cell_valid || o_cell_index == 3'($past(o_cell_index) + 3'd1), "cells out of order")
    `GNR_ASSERT_IMP(a_last_flag, o_cell_valid, o_last_cell == (o_cell_index == 3'(CELLS - 1)), "last flag off cell 7")
    `GNR_ASSERT_IMP(a_needle_len, r_state == ST_EMIT, $countones(r_slot_v) >= 6, "needle too short")
    `GNR_ASSERT_IMP(a_pix_canvas, pix.valid, pix.x < 5'd20, "needle pixel off canvas")

endmodule

`default_nettype wire

### tb/tb_gauge_needle_renderer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for gauge_needle_renderer_core: a directed table of readings and
// full-scale writes, then random phases. Depends on gnr_pkg and the core RTL only.

module tb_gauge_needle_renderer_core;
    import gnr_pkg::BITMAP_W;
    import gnr_pkg::REG_FULL_SCALE;

    // Eight cells of eight 5-bit pixel rows, cell and row 0 first.
    typedef logic [0:7][0:7][4:0] t_frame;

    typedef enum logic [1:0] {
        WANT_MODEL,
        WANT_REST,
        WANT_FULL
    } t_want;

    typedef enum logic {
        ROW_READING,
        ROW_FULL_SCALE
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] value;
        t_want      want;
    } t_row;

    typedef struct packed {
        logic [2:0]          index;
        logic [BITMAP_W-1:0] bitmap;
        logic                last;
    } t_cell;

    localparam logic [7:0] FULL_SCALE_AT_RESET = 8'd90;
    localparam logic [2:0] FULL_SCALE_ADDR     = {REG_FULL_SCALE, 2'b00};
    localparam int ANGLE_BASE = 112 * 256;
    localparam int ANGLE_SPAN = 300 - 112;
    localparam int PIVOT_X    = 10;
    localparam int PIVOT_Y    = 8;
    localparam int CELL_COUNT = 8;

    localparam t_frame DIAL = '{
        '{5'h00, 5'h00, 5'h00, 5'h01, 5'h03, 5'h02, 5'h02, 5'h02},
        '{5'h07, 5'h08, 5'h18, 5'h04, 5'h00, 5'h10, 5'h00, 5'h00},
        '{5'h1E, 5'h11, 5'h11, 5'h02, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h10, 5'h08, 5'h0C, 5'h14, 5'h04, 5'h04},
        '{5'h03, 5'h02, 5'h02, 5'h02, 5'h01, 5'h00, 5'h00, 5'h00},
        '{5'h10, 5'h00, 5'h00, 5'h08, 5'h10, 5'h12, 5'h0C, 5'h07},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h01, 5'h1E},
        '{5'h1C, 5'h04, 5'h04, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00}
    };

    // Needle at 112 degrees: tip at (7,14), drawn through cells 5 and 6.
    localparam t_frame NEEDLE_REST = '{
        '{5'h00, 5'h00, 5'h00, 5'h01, 5'h03, 5'h02, 5'h02, 5'h02},
        '{5'h07, 5'h08, 5'h18, 5'h04, 5'h00, 5'h10, 5'h00, 5'h00},
        '{5'h1E, 5'h11, 5'h11, 5'h02, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h10, 5'h08, 5'h0C, 5'h14, 5'h04, 5'h04},
        '{5'h03, 5'h02, 5'h02, 5'h02, 5'h01, 5'h00, 5'h00, 5'h00},
        '{5'h10, 5'h00, 5'h01, 5'h09, 5'h12, 5'h12, 5'h0C, 5'h07},
        '{5'h10, 5'h10, 5'h00, 5'h00, 5'h00, 5'h00, 5'h01, 5'h1E},
        '{5'h1C, 5'h04, 5'h04, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00}
    };

    // Needle at 300 degrees: tip at (14,2), drawn through cells 2 and 6.
    localparam t_frame NEEDLE_FULL = '{
        '{5'h00, 5'h00, 5'h00, 5'h01, 5'h03, 5'h02, 5'h02, 5'h02},
        '{5'h07, 5'h08, 5'h18, 5'h04, 5'h00, 5'h10, 5'h00, 5'h00},
        '{5'h1E, 5'h11, 5'h11, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08},
        '{5'h00, 5'h00, 5'h10, 5'h08, 5'h0C, 5'h14, 5'h04, 5'h04},
        '{5'h03, 5'h02, 5'h02, 5'h02, 5'h01, 5'h00, 5'h00, 5'h00},
        '{5'h10, 5'h00, 5'h00, 5'h08, 5'h10, 5'h12, 5'h0C, 5'h07},
        '{5'h10, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h01, 5'h1E},
        '{5'h1C, 5'h04, 5'h04, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00}
    };

    // Tip offsets by angle in 1/256 degree; each value holds from its threshold on.
    localparam int TIP_DX_FROM [16] = '{
        0, 30720, 33282, 36298, 40503, 51658, 55863, 58879,
        61441, 63764, 65953, 68072, 70169, 72288, 74477, 76800
    };
    localparam int TIP_DX [16] = '{
        -3, -4, -5, -6, -7, -6, -5, -4, -3, -2, -1, 0, 1, 2, 3, 4
    };
    localparam int TIP_DY_FROM [15] = '{
        0, 32823, 35839, 38401, 40724, 42913, 45032, 47129,
        49248, 51437, 53760, 56322, 59338, 63543, 74698
    };
    localparam int TIP_DY [15] = '{
        6, 5, 4, 3, 2, 1, 0, -1, -2, -3, -4, -5, -6, -7, -6
    };

    // The half-way angles 120, 150, 180, 210 and 240 degrees come from scales 47 and 94.
    localparam t_row DIRECTED [27] = '{
        '{ROW_READING,    8'd0,   WANT_REST},
        '{ROW_READING,    8'd90,  WANT_FULL},
        '{ROW_READING,    8'd255, WANT_FULL},
        '{ROW_READING,    8'd45,  WANT_MODEL},
        '{ROW_READING,    8'd170, WANT_FULL},
        '{ROW_READING,    8'd85,  WANT_MODEL},
        '{ROW_FULL_SCALE, 8'd0,   WANT_MODEL},
        '{ROW_READING,    8'd0,   WANT_REST},
        '{ROW_READING,    8'd255, WANT_REST},
        '{ROW_READING,    8'd128, WANT_REST},
        '{ROW_FULL_SCALE, 8'd255, WANT_MODEL},
        '{ROW_READING,    8'd255, WANT_FULL},
        '{ROW_READING,    8'd254, WANT_MODEL},
        '{ROW_READING,    8'd1,   WANT_MODEL},
        '{ROW_FULL_SCALE, 8'd47,  WANT_MODEL},
        '{ROW_READING,    8'd2,   WANT_MODEL},
        '{ROW_READING,    8'd17,  WANT_MODEL},
        '{ROW_READING,    8'd32,  WANT_MODEL},
        '{ROW_READING,    8'd47,  WANT_FULL},
        '{ROW_FULL_SCALE, 8'd94,  WANT_MODEL},
        '{ROW_READING,    8'd19,  WANT_MODEL},
        '{ROW_READING,    8'd49,  WANT_MODEL},
        '{ROW_READING,    8'd93,  WANT_MODEL},
        '{ROW_FULL_SCALE, 8'd1,   WANT_MODEL},
        '{ROW_READING,    8'd1,   WANT_FULL},
        '{ROW_READING,    8'd0,   WANT_REST},
        '{ROW_READING,    8'd2,   WANT_FULL}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_psi_valid = 1'b0;
    logic                o_psi_stall;
    logic [7:0]          i_psi = '0;
    logic                o_cell_valid;
    logic                i_cell_stall = 1'b0;
    logic [2:0]          o_cell_index;
    logic [BITMAP_W-1:0] o_cell_bitmap;
    logic                o_last_cell;

    t_cell      cell_q [$];
    logic [7:0] full_scale = FULL_SCALE_AT_RESET;
    int         faults = 0;
    int         readings = 0;
    int         cells_seen = 0;
    int         scale_writes = 0;
    bit         in_calm = 1'b0;
    bit         out_calm = 1'b0;
    int         out_hold = 0;

    gauge_needle_renderer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_psi_valid   (i_psi_valid),
        .o_psi_stall   (o_psi_stall),
        .i_psi         (i_psi),
        .o_cell_valid  (o_cell_valid),
        .i_cell_stall  (i_cell_stall),
        .o_cell_index  (o_cell_index),
        .o_cell_bitmap (o_cell_bitmap),
        .o_last_cell   (o_last_cell)
    );

    always #5 i_clk = ~i_clk;

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // Dial picture with the needle for one reading at the given full scale.
    function automatic t_frame render_frame(input logic [7:0] psi, input logic [7:0] fs);
        t_frame f;
        int     p, ang, dx, dy, u0, v0, u1, v1, du, dv, step, d, v, px, py, tmp;
        bit     steep;
        f   = DIAL;
        ang = ANGLE_BASE;
        if (fs != 8'd0) begin
            p   = (psi > fs) ? int'(fs) : int'(psi);
            ang = ang + (ANGLE_SPAN * 256 * p) / int'(fs);
        end
        dx = TIP_DX[0];
        for (int i = 1; i < 16; i++) begin
            if (ang >= TIP_DX_FROM[i]) dx = TIP_DX[i];
        end
        dy = TIP_DY[0];
        for (int i = 1; i < 15; i++) begin
            if (ang >= TIP_DY_FROM[i]) dy = TIP_DY[i];
        end
        // Walk the major axis upward from the lower end; ties count as steep.
        steep = ((dy < 0) ? -dy : dy) >= ((dx < 0) ? -dx : dx);
        if (steep) begin
            u0 = PIVOT_Y; v0 = PIVOT_X; u1 = PIVOT_Y + dy; v1 = PIVOT_X + dx;
        end else begin
            u0 = PIVOT_X; v0 = PIVOT_Y; u1 = PIVOT_X + dx; v1 = PIVOT_Y + dy;
        end
        if (u0 > u1) begin
            tmp = u0; u0 = u1; u1 = tmp;
            tmp = v0; v0 = v1; v1 = tmp;
        end
        du   = u1 - u0;
        dv   = v1 - v0;
        step = 1;
        if (dv < 0) begin
            step = -1;
            dv   = -dv;
        end
        d = 2 * dv - du;
        v = v0;
        for (int u = u0; u <= u1; u++) begin
            px = steep ? v : u;
            py = steep ? u : v;
            if (px >= 0 && px < 20 && py >= 0 && py < 16) begin
                f[(py / 8) * 4 + px / 5][py % 8][4 - px % 5] = 1'b1;
            end
            if (d > 0) begin
                v = v + step;
                d = d - 2 * du;
            end
            d = d + 2 * dv;
        end
        return f;
    endfunction

    task automatic note_fault(input string msg);
        if (faults < 10) $display("%0t: %s", $time, msg);
        faults++;
    endtask

    task automatic send_reading(input logic [7:0] psi, input t_want want);
        t_frame              f;
        t_cell               c;
        int                  gap;
        logic [BITMAP_W-1:0] bits;
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
        gap = draw_wait(in_calm);
        if (gap > 0) begin
            i_psi_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_psi_valid <= 1'b1;
        i_psi       <= psi;
        do @(posedge i_clk); while (o_psi_stall);
        case (want)
            WANT_REST: f = NEEDLE_REST;
            WANT_FULL: f = NEEDLE_FULL;
            default:   f = render_frame(psi, full_scale);
        endcase
        for (int k = 0; k < CELL_COUNT; k++) begin
            for (int r = 0; r < 8; r++) bits[5 * r +: 5] = f[k][r];
            c.index  = 3'(k);
            c.bitmap = bits;
            c.last   = (k == CELL_COUNT - 1);
            cell_q.push_back(c);
        end
        readings++;
    endtask

    // Writes full_scale_psi once the frame in flight has drained, then reads it back.
    task automatic set_full_scale(input logic [7:0] fs);
        i_psi_valid <= 1'b0;
        while (cell_q.size() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FULL_SCALE_ADDR;
        pwdata  <= {24'd0, fs};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel       <= 1'b0;
        penable    <= 1'b0;
        full_scale  = fs;
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== fs) begin
            note_fault($sformatf("full_scale_psi read back %h, expected %h", prdata[7:0], fs));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        scale_writes++;
    endtask

    // Cell checker and output stall generator.
    always @(posedge i_clk) begin
        t_cell want;
        t_cell got;
        if (i_rst_n) begin
            if (o_cell_valid && !i_cell_stall) begin
                got = {o_cell_index, o_cell_bitmap, o_last_cell};
                cells_seen++;
                if (cell_q.size() == 0) begin
                    note_fault($sformatf("unexpected cell: index %0d bitmap %h last %b",
                                         got.index, got.bitmap, got.last));
                end else begin
                    want = cell_q.pop_front();
                    if (got !== want) begin
                        note_fault($sformatf(
                            "cell mismatch: expected index %0d bitmap %h last %b, got %0d %h %b",
                            want.index, want.bitmap, want.last,
                            got.index, got.bitmap, got.last));
                    end
                end
                if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
                out_hold = draw_wait(out_calm);
            end
            if (out_hold > 0) begin
                i_cell_stall <= 1'b1;
                out_hold--;
            end else begin
                i_cell_stall <= 1'b0;
            end
        end
    end

    initial begin
        logic [7:0] fs;
        logic [7:0] psi;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].kind == ROW_FULL_SCALE) begin
                set_full_scale(DIRECTED[k].value);
            end else begin
                send_reading(DIRECTED[k].value, DIRECTED[k].want);
            end
        end
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 4))
                0: fs = 8'd0;
                1: fs = 8'd255;
                2: fs = 8'($urandom_range(1, 6));
                default: fs = 8'($urandom);
            endcase
            set_full_scale(fs);
            // Mostly readings within the scale, with the ends and overrange mixed in.
            for (int n = 0; n < 40; n++) begin
                case ($urandom_range(0, 7))
                    0: psi = 8'd0;
                    1: psi = fs;
                    2: psi = 8'($urandom_range(fs, 255));
                    default: psi = 8'($urandom_range(0, fs));
                endcase
                send_reading(psi, WANT_MODEL);
            end
        end
        i_psi_valid <= 1'b0;
        while (cell_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (cell_q.size() != 0) begin
            note_fault($sformatf("%0d cells never arrived", cell_q.size()));
        end
        $display("Checked %0d cells from %0d readings across %0d full-scale writes, %0d faults.",
                 cells_seen, readings, scale_writes, faults);
        if (faults == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run did not finish in time.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
